// ===== hw/rtl/ilir_pkg.sv =====
// -----------------------------------------------------------------------------
// ilir_pkg - shared definitions for the indexed list core
// Sizes, operation and status codes, payload types and the cell control word.
// -----------------------------------------------------------------------------
package ilir_pkg;

	// Sizes
	localparam int CAPACITY   = 64;
	localparam int FUNC_W     = 2;
	localparam int POS_W      = 7;
	localparam int DATA_W     = 32;
	localparam int STAT_W     = 2;
	localparam int CNT_W      = 7;
	localparam int GROUP_SIZE = 8;
	localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int CMP_W      = $clog2(CAPACITY) + POS_W;

	// Payload types
	typedef logic [FUNC_W-1:0]        func_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [STAT_W-1:0]        status_t;
	typedef logic [CNT_W-1:0]         count_t;

	// Operation codes
	localparam func_t OP_INSERT = 2'd0;
	localparam func_t OP_REMOVE = 2'd1;
	localparam func_t OP_GET    = 2'd2;

	// Status codes
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_BAD_POS = 2'd1;
	localparam status_t ST_FULL    = 2'd2;

	// Per-cell control for one accepted request
	typedef struct packed {
		logic load;       // take the inserted word
		logic shift_up;   // take the left neighbor's word
		logic shift_down; // take the right neighbor's word
		logic sel;        // drive the held word onto the read tree
	} cell_ctl_t;

endpackage

// ===== hw/rtl/ilir_req_if.sv =====
// -----------------------------------------------------------------------------
// ilir_req_if - request channel
// Valid/ready channel carrying one list request.
// -----------------------------------------------------------------------------
interface ilir_req_if import ilir_pkg::*; ();
	logic  valid;
	logic  ready;
	func_t func;
	pos_t  position;
	data_t item_value;

	modport source (output valid, output func, output position, output item_value,
		input ready);
	modport sink (input valid, input func, input position, input item_value,
		output ready);
endinterface

// ===== hw/rtl/ilir_rsp_if.sv =====
// -----------------------------------------------------------------------------
// ilir_rsp_if - response channel
// Valid/ready channel carrying one list result.
// -----------------------------------------------------------------------------
interface ilir_rsp_if import ilir_pkg::*; ();
	logic    valid;
	logic    ready;
	data_t   read_value;
	status_t status;
	count_t  entry_count;

	modport source (output valid, output read_value, output status, output entry_count,
		input ready);
	modport sink (input valid, input read_value, input status, input entry_count,
		output ready);
endinterface

// ===== hw/rtl/indexed_list_insert_remove_core.sv =====
// -----------------------------------------------------------------------------
// indexed_list_insert_remove_core - positional list of signed words
// Insert, remove and get by position over a row of shifting cells.
//
//  channel | dir | fields                               | transfer when
//  req     | in  | func, position, item_value           | req.valid & req.ready
//  rsp     | out | read_value, status, entry_count      | rsp.valid & rsp.ready
//
// One request is taken per cycle while the response is not stalled; the
// result passes stage 1 and the output register. All cells shift or hold
// in parallel at the request transfer; a get reads the read tree's group
// registers. Reset clears the count and valid bits; cell contents are left
// as is. A stalled result holds; one more request waits behind it in stage 1.
// -----------------------------------------------------------------------------
module indexed_list_insert_remove_core import ilir_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ilir_req_if.sink   req,
	ilir_rsp_if.source rsp
);

	logic      accept;
	logic      move_s1;
	logic      v_s1;
	logic      rsp_v_q;
	count_t    cnt_q;
	count_t    cnt_next;
	status_t   status_d;
	logic      ins_do;
	logic      rem_do;
	logic      get_ok_d;
	logic      neg1_d;
	logic      get_ok_s1;
	logic      neg1_s1;
	status_t   status_s1;
	count_t    cnt_s1;
	data_t     read_value_q;
	status_t   status_q;
	count_t    entry_count_q;
	logic [CMP_W-1:0] pos_x;
	cell_ctl_t ctl [CAPACITY];
	data_t     cell_word [CAPACITY];
	data_t     cell_rd [CAPACITY];
	data_t     tree_word;

	// Handshake and stage flow
	assign accept    = req.valid && req.ready;
	assign move_s1   = v_s1 && (!rsp_v_q || rsp.ready);
	assign req.ready = !v_s1 || move_s1;

	// Decode the request against the current count
	always_comb begin
		status_d = ST_OK;
		cnt_next = cnt_q;
		ins_do   = 1'b0;
		rem_do   = 1'b0;
		get_ok_d = 1'b0;
		neg1_d   = 1'b0;
		unique case (req.func)
			OP_INSERT: begin
				if (CNT_W'(req.position) > cnt_q) begin
					status_d = ST_BAD_POS;
				end else if (cnt_q >= CNT_W'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					ins_do   = 1'b1;
					cnt_next = cnt_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (CNT_W'(req.position) >= cnt_q) begin
					status_d = ST_BAD_POS;
				end else begin
					rem_do   = 1'b1;
					cnt_next = cnt_q - 1'b1;
				end
			end
			OP_GET: begin
				if (CNT_W'(req.position) >= cnt_q) begin
					status_d = ST_BAD_POS;
					neg1_d   = 1'b1;
				end else begin
					get_ok_d = 1'b1;
				end
			end
			default: begin
				status_d = ST_BAD_POS;
			end
		endcase
	end

	// Per-cell control from the position
	assign pos_x = CMP_W'(req.position);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign ctl[i].load       = accept && ins_do && (pos_x == CMP_W'(i));
		assign ctl[i].shift_up   = accept && ins_do && (pos_x < CMP_W'(i));
		assign ctl[i].shift_down = accept && rem_do && (pos_x <= CMP_W'(i));
		assign ctl[i].sel        = pos_x == CMP_W'(i);

		if (i == 0) begin : g_first
			if (CAPACITY > 1) begin : g_more
				ilir_cell u_cell (
					.clk     (clk),
					.ctl     (ctl[i]),
					.value   (req.item_value),
					.left    (req.item_value),
					.right   (cell_word[i + 1]),
					.word    (cell_word[i]),
					.rd_word (cell_rd[i])
				);
			end else begin : g_one
				ilir_cell u_cell (
					.clk     (clk),
					.ctl     (ctl[i]),
					.value   (req.item_value),
					.left    (req.item_value),
					.right   ('0),
					.word    (cell_word[i]),
					.rd_word (cell_rd[i])
				);
			end
		end else if (i == CAPACITY - 1) begin : g_last
			ilir_cell u_cell (
				.clk     (clk),
				.ctl     (ctl[i]),
				.value   (req.item_value),
				.left    (cell_word[i - 1]),
				.right   ('0),
				.word    (cell_word[i]),
				.rd_word (cell_rd[i])
			);
		end else begin : g_mid
			ilir_cell u_cell (
				.clk     (clk),
				.ctl     (ctl[i]),
				.value   (req.item_value),
				.left    (cell_word[i - 1]),
				.right   (cell_word[i + 1]),
				.word    (cell_word[i]),
				.rd_word (cell_rd[i])
			);
		end
	end

	// Read tree for get
	ilir_rtree u_rtree (
		.clk     (clk),
		.load    (accept),
		.words   (cell_rd),
		.rd_data (tree_word)
	);

	// Control state: count and stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			v_s1    <= 1'b0;
			rsp_v_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_next;
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (move_s1) begin
				v_s1 <= 1'b0;
			end
			if (move_s1) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	// Stage 1 result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			cnt_s1    <= cnt_next;
			get_ok_s1 <= get_ok_d;
			neg1_s1   <= neg1_d;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (move_s1) begin
			status_q      <= status_s1;
			entry_count_q <= cnt_s1;
			if (get_ok_s1) begin
				read_value_q <= tree_word;
			end else if (neg1_s1) begin
				read_value_q <= '1;
			end else begin
				read_value_q <= '0;
			end
		end
	end

	assign rsp.valid       = rsp_v_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = entry_count_q;

endmodule

// ===== hw/rtl/ilir_cell.sv =====
// -----------------------------------------------------------------------------
// ilir_cell - one list slot
// Holds one word; loads, shifts from either neighbor or holds, and gates its
// word onto the read tree when selected.
// -----------------------------------------------------------------------------
module ilir_cell import ilir_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  data_t     value,
	input  data_t     left,
	input  data_t     right,
	output data_t     word,
	output data_t     rd_word
);

	data_t word_q;

	// Load, shift or hold the slot
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			word_q <= value;
		end else if (ctl.shift_up) begin
			word_q <= left;
		end else if (ctl.shift_down) begin
			word_q <= right;
		end
	end

	assign word    = word_q;
	assign rd_word = ctl.sel ? word_q : '0;

endmodule

// ===== hw/rtl/ilir_rtree.sv =====
// -----------------------------------------------------------------------------
// ilir_rtree - registered read tree
// ORs the gated cell words in groups into a register stage, then ORs the
// group registers into one word.
// -----------------------------------------------------------------------------
module ilir_rtree import ilir_pkg::*; (
	input  logic  clk,
	input  logic  load,
	input  data_t words [CAPACITY],
	output data_t rd_data
);

	data_t grp_d [NUM_GROUPS];
	data_t grp_s1 [NUM_GROUPS];
	data_t acc;

	// Reduce each group of cells
	always_comb begin
		for (int g = 0; g < NUM_GROUPS; g++) begin
			grp_d[g] = '0;
			for (int j = 0; j < GROUP_SIZE; j++) begin
				if (g * GROUP_SIZE + j < CAPACITY) begin
					grp_d[g] = grp_d[g] | words[g * GROUP_SIZE + j];
				end
			end
		end
	end

	// Capture group results on request transfer
	always_ff @(posedge clk) begin
		if (load) begin
			grp_s1 <= grp_d;
		end
	end

	// Reduce the group registers
	always_comb begin
		acc = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			acc = acc | grp_s1[g];
		end
	end

	assign rd_data = acc;

endmodule

// ===== hw/rtl/ilir_checker.sv =====
// -----------------------------------------------------------------------------
// ilir_checker - port checks for the indexed list core
// Watches the response channel and flags stalls that drop data or results
// that break the status and count rules.
// -----------------------------------------------------------------------------
module ilir_checker import ilir_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    rsp_valid,
	input logic    rsp_ready,
	input data_t   rsp_read_value,
	input status_t rsp_status,
	input count_t  rsp_entry_count
);

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
			&& $stable(rsp_status) && $stable(rsp_entry_count))
		else $error("stalled response changed");

	// A full status only when the list is at capacity, and reads nothing
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |->
			rsp_entry_count == CNT_W'(CAPACITY) && rsp_read_value == '0)
		else $error("full status with count below capacity");

	// Count never exceeds capacity
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_entry_count <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// Unused status code never appears
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_BAD_POS
			|| rsp_status == ST_FULL)
		else $error("undefined status code");

endmodule

bind indexed_list_insert_remove_core ilir_checker u_ilir_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_read_value  (rsp.read_value),
	.rsp_status      (rsp.status),
	.rsp_entry_count (rsp.entry_count)
);
